/* sv/addp_pkg.sv */
// Shared types and constants for the access distance diversity profiler.
// No dependencies.
package addp_pkg;

  localparam int unsigned BLOCK_SHIFT = 6;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned BLOCK_W     = ADDR_W - BLOCK_SHIFT;
  localparam int unsigned COUNT_W     = 64;
  localparam int unsigned BIN_W       = 32;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned NZ_W        = 9;
  localparam int unsigned CFG_W       = 32;
  localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd1000000;
  localparam logic [BIN_W-1:0] BIN_MAX        = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_UPD,
    ST_DRAIN,
    ST_PUSH,
    ST_RPT_INIT,
    ST_RPT_SCAN,
    ST_RPT_DRAIN,
    ST_RPT_SUM,
    ST_RPT_OUT
  } state_e;

  typedef struct packed {
    logic in_take;    // latch the accepted word
    logic upd_issue;  // read one history entry into the update pipe
    logic hist_wr;    // push the block into the history ring
    logic clr_wr;     // zero the bin at the table index
    logic scan_issue; // read the bin at the table index for the report
    logic acc_clr;    // clear report accumulators
    logic sum_step;   // add the largest kept bin and shift the list
    logic out_load;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic is_mem;
    logic rpt;
    logic pipe_busy;
  } status_t;

endpackage

/* sv/addp_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Read during write to the same address returns the old data.
module addp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/addp_ctrl.sv */
// Controller: sequences updates, history pushes, clearing and reports.
// Depends on addp_pkg.
module addp_ctrl #(
  parameter int unsigned TABLE_SIZE    = 256,
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned TOP_N         = 8,
  parameter int unsigned TW = $clog2(TABLE_SIZE),
  parameter int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  addp_pkg::status_t  st_i,
  output addp_pkg::cmd_t     cmd_o,
  output logic [TW-1:0]      tbl_idx_o,
  output logic [HW-1:0]      hist_idx_o,
  output logic [HW-1:0]      head_o
);

  localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned NW = (TOP_N > 1) ? $clog2(TOP_N) : 1;

  addp_pkg::state_e state_q, state_d;
  logic [TW-1:0] tbl_idx_q;
  logic [HW-1:0] hist_idx_q, head_q;
  logic [FW-1:0] fill_q;
  logic [NW-1:0] sum_idx_q;
  logic          out_valid_q;

  logic tbl_last, hist_last, sum_last, out_free;

  assign tbl_last  = (tbl_idx_q == TW'(TABLE_SIZE - 1));
  assign hist_last = ((FW'(hist_idx_q) + FW'(1)) == fill_q);
  assign sum_last  = (sum_idx_q == NW'(TOP_N - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      addp_pkg::ST_CLEAR:     if (tbl_last) state_d = addp_pkg::ST_IDLE;
      addp_pkg::ST_IDLE:      if (in_valid_i) state_d = addp_pkg::ST_DECIDE;
      addp_pkg::ST_DECIDE: begin
        if (st_i.is_mem) begin
          state_d = (fill_q == '0) ? addp_pkg::ST_PUSH : addp_pkg::ST_UPD;
        end else begin
          state_d = st_i.rpt ? addp_pkg::ST_RPT_INIT : addp_pkg::ST_IDLE;
        end
      end
      addp_pkg::ST_UPD:       if (hist_last) state_d = addp_pkg::ST_DRAIN;
      addp_pkg::ST_DRAIN:     if (!st_i.pipe_busy) state_d = addp_pkg::ST_PUSH;
      addp_pkg::ST_PUSH: begin
        state_d = st_i.rpt ? addp_pkg::ST_RPT_INIT : addp_pkg::ST_IDLE;
      end
      addp_pkg::ST_RPT_INIT:  state_d = addp_pkg::ST_RPT_SCAN;
      addp_pkg::ST_RPT_SCAN:  if (tbl_last) state_d = addp_pkg::ST_RPT_DRAIN;
      addp_pkg::ST_RPT_DRAIN: state_d = addp_pkg::ST_RPT_SUM;
      addp_pkg::ST_RPT_SUM:   if (sum_last) state_d = addp_pkg::ST_RPT_OUT;
      addp_pkg::ST_RPT_OUT:   if (out_free) state_d = addp_pkg::ST_IDLE;
      default:                state_d = addp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      addp_pkg::ST_CLEAR:     cmd_o.clr_wr = 1'b1;
      addp_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.in_take = in_valid_i;
      end
      addp_pkg::ST_UPD:       cmd_o.upd_issue = 1'b1;
      addp_pkg::ST_PUSH:      cmd_o.hist_wr = 1'b1;
      addp_pkg::ST_RPT_INIT:  cmd_o.acc_clr = 1'b1;
      addp_pkg::ST_RPT_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        cmd_o.clr_wr     = 1'b1;
      end
      addp_pkg::ST_RPT_SUM:   cmd_o.sum_step = 1'b1;
      addp_pkg::ST_RPT_OUT:   cmd_o.out_load = out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= addp_pkg::ST_CLEAR;
      tbl_idx_q   <= '0;
      hist_idx_q  <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      sum_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == addp_pkg::ST_CLEAR || state_q == addp_pkg::ST_RPT_SCAN) begin
        tbl_idx_q <= tbl_last ? '0 : tbl_idx_q + TW'(1);
      end
      if (state_q == addp_pkg::ST_UPD) begin
        hist_idx_q <= hist_last ? '0 : hist_idx_q + HW'(1);
      end
      if (state_q == addp_pkg::ST_RPT_SUM) begin
        sum_idx_q <= sum_last ? '0 : sum_idx_q + NW'(1);
      end
      if (state_q == addp_pkg::ST_PUSH) begin
        head_q <= (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + HW'(1);
        if (fill_q != FW'(HISTORY_DEPTH)) begin
          fill_q <= fill_q + FW'(1);
        end
      end
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign tbl_idx_o   = tbl_idx_q;
  assign hist_idx_o  = hist_idx_q;
  assign head_o      = head_q;
  assign out_valid_o = out_valid_q;

endmodule

/* sv/addp_dp.sv */
// Datapath: history and bin memories, update pipe, interval counting,
// top-N list and report accumulators. Depends on addp_pkg and addp_ram.
module addp_dp #(
  parameter int unsigned TABLE_SIZE    = 256,
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned TOP_N         = 8,
  parameter int unsigned TW = $clog2(TABLE_SIZE),
  parameter int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  addp_pkg::cmd_t                   cmd_i,
  output addp_pkg::status_t                st_o,
  input  logic [TW-1:0]                    tbl_idx_i,
  input  logic [HW-1:0]                    hist_idx_i,
  input  logic [HW-1:0]                    head_i,
  input  logic                             cfg_we_i,
  input  logic [addp_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                             in_is_memory_i,
  input  logic [addp_pkg::ADDR_W-1:0]      in_access_address_i,
  input  logic [addp_pkg::COUNT_W-1:0]     in_retired_count_i,
  output logic [addp_pkg::COUNT_W-1:0]     out_report_count_o,
  output logic [addp_pkg::SUM_W-1:0]       out_top_bins_sum_o,
  output logic [addp_pkg::NZ_W-1:0]        out_nonzero_bins_o,
  output logic [addp_pkg::SUM_W-1:0]       out_all_bins_sum_o
);

  localparam int unsigned NZW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned CW  = addp_pkg::CFG_W;
  localparam int unsigned BW  = addp_pkg::BIN_W;

  // interval counting
  logic [CW-1:0] cfg_q, count_q, drift_q, count_inc, len;
  logic [CW:0]   sum_w;
  logic          rpt_hit, rpt_q, is_mem_q;

  assign len       = (cfg_q == '0) ? CW'(1) : cfg_q;
  assign count_inc = count_q + CW'(1);
  assign sum_w     = {1'b0, count_inc} + {1'b0, drift_q};
  assign rpt_hit   = (sum_w >= {1'b0, len});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= addp_pkg::INTERVAL_RESET;
      count_q  <= '0;
      drift_q  <= '0;
      rpt_q    <= 1'b0;
      is_mem_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.in_take) begin
        is_mem_q <= in_is_memory_i;
        rpt_q    <= rpt_hit;
        if (rpt_hit) begin
          count_q <= '0;
          drift_q <= CW'(sum_w - {1'b0, len});
        end else begin
          count_q <= count_inc;
        end
      end
    end
  end

  logic [addp_pkg::BLOCK_W-1:0] blk_q;
  logic [addp_pkg::COUNT_W-1:0] rcount_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      blk_q    <= in_access_address_i[addp_pkg::ADDR_W-1:addp_pkg::BLOCK_SHIFT];
      rcount_q <= in_retired_count_i;
    end
  end

  // history ring
  logic [addp_pkg::BLOCK_W-1:0] hist_rdata;

  addp_ram #(
    .WIDTH (addp_pkg::BLOCK_W),
    .DEPTH (HISTORY_DEPTH),
    .AW    (HW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist_wr),
    .waddr_i (head_i),
    .wdata_i (blk_q),
    .raddr_i (hist_idx_i),
    .rdata_o (hist_rdata)
  );

  // update pipe: history read, bin read, bin write with forwarding
  logic          v1_q, v2_q, s1_q, wr_v_q;
  logic [TW-1:0] bin_b, bin_c_q, wr_addr_q;
  logic [BW-1:0] wr_data_q, bin_rdata, bin_cur, bin_inc;
  logic          bin_we;
  logic [TW-1:0] bin_waddr, bin_raddr;
  logic [BW-1:0] bin_wdata;

  assign bin_b   = blk_q[TW-1:0] - hist_rdata[TW-1:0];
  assign bin_cur = (wr_v_q && wr_addr_q == bin_c_q) ? wr_data_q : bin_rdata;
  assign bin_inc = (bin_cur == addp_pkg::BIN_MAX) ? bin_cur : bin_cur + BW'(1);

  assign bin_raddr = cmd_i.scan_issue ? tbl_idx_i : bin_b;
  assign bin_we    = cmd_i.clr_wr || v2_q;
  assign bin_waddr = cmd_i.clr_wr ? tbl_idx_i : bin_c_q;
  assign bin_wdata = cmd_i.clr_wr ? '0 : bin_inc;

  addp_ram #(
    .WIDTH (BW),
    .DEPTH (TABLE_SIZE),
    .AW    (TW)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      s1_q   <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      v1_q   <= cmd_i.upd_issue;
      v2_q   <= v1_q;
      s1_q   <= cmd_i.scan_issue;
      wr_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_c_q   <= bin_b;
    wr_addr_q <= bin_c_q;
    wr_data_q <= bin_inc;
  end

  // report: running top-N list (descending), totals
  logic [BW-1:0]                top_q [TOP_N];
  logic [BW-1:0]                top_d [TOP_N];
  logic [TOP_N-1:0]             gt;
  logic [addp_pkg::SUM_W-1:0]   all_q, topsum_q;
  logic [NZW-1:0]               nz_q;

  always_comb begin
    for (int k = 0; k < TOP_N; k++) begin
      gt[k] = (bin_rdata > top_q[k]);
    end
    for (int k = 0; k < TOP_N; k++) begin
      top_d[k] = top_q[k];
    end
    if (cmd_i.acc_clr) begin
      for (int k = 0; k < TOP_N; k++) begin
        top_d[k] = '0;
      end
    end else if (cmd_i.sum_step) begin
      for (int k = 0; k < TOP_N - 1; k++) begin
        top_d[k] = top_q[k + 1];
      end
      top_d[TOP_N-1] = '0;
    end else if (s1_q) begin
      if (gt[0]) top_d[0] = bin_rdata;
      for (int k = 1; k < TOP_N; k++) begin
        if (gt[k]) top_d[k] = gt[k-1] ? top_q[k-1] : bin_rdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TOP_N; k++) begin
      top_q[k] <= top_d[k];
    end
    if (cmd_i.acc_clr) begin
      all_q    <= '0;
      nz_q     <= '0;
      topsum_q <= '0;
    end else begin
      if (s1_q) begin
        all_q <= all_q + addp_pkg::SUM_W'(bin_rdata);
        if (bin_rdata != '0) nz_q <= nz_q + NZW'(1);
      end
      if (cmd_i.sum_step) begin
        topsum_q <= topsum_q + addp_pkg::SUM_W'(top_q[0]);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_report_count_o <= rcount_q;
      out_top_bins_sum_o <= topsum_q;
      out_nonzero_bins_o <= addp_pkg::NZ_W'(nz_q);
      out_all_bins_sum_o <= all_q;
    end
  end

  assign st_o.is_mem    = is_mem_q;
  assign st_o.rpt       = rpt_q;
  assign st_o.pipe_busy = v1_q || v2_q;

endmodule

/* sv/access_distance_diversity_profiler_unit.sv */
// Top level of the access distance diversity profiler: controller plus datapath.
// A word that is no access goes back to idle after its decision; an access reads each valid
// history entry (up to HISTORY_DEPTH, none with an empty history), does one bin read-modify-write
// per entry through the single bin write port, drains the update pipe and pushes its block.
// A closing word adds one pass over the bin memory, then the top-N sum.
// After reset the bins are zeroed before the first word is taken.
module access_distance_diversity_profiler_unit #(
  parameter int unsigned TABLE_SIZE    = 256,
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned TOP_N         = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [addp_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_is_memory_i,
  input  logic [addp_pkg::ADDR_W-1:0]  in_access_address_i,
  input  logic [addp_pkg::COUNT_W-1:0] in_retired_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [addp_pkg::COUNT_W-1:0] out_report_count_o,
  output logic [addp_pkg::SUM_W-1:0]   out_top_bins_sum_o,
  output logic [addp_pkg::NZ_W-1:0]    out_nonzero_bins_o,
  output logic [addp_pkg::SUM_W-1:0]   out_all_bins_sum_o
);

  localparam int unsigned TW = $clog2(TABLE_SIZE);
  localparam int unsigned HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  addp_pkg::cmd_t    cmd;
  addp_pkg::status_t st;
  logic [TW-1:0]     tbl_idx;
  logic [HW-1:0]     hist_idx, head;

  addp_ctrl #(
    .TABLE_SIZE    (TABLE_SIZE),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TOP_N         (TOP_N),
    .TW            (TW),
    .HW            (HW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd),
    .tbl_idx_o   (tbl_idx),
    .hist_idx_o  (hist_idx),
    .head_o      (head)
  );

  addp_dp #(
    .TABLE_SIZE    (TABLE_SIZE),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TOP_N         (TOP_N),
    .TW            (TW),
    .HW            (HW)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .st_o                (st),
    .tbl_idx_i           (tbl_idx),
    .hist_idx_i          (hist_idx),
    .head_i              (head),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_is_memory_i      (in_is_memory_i),
    .in_access_address_i (in_access_address_i),
    .in_retired_count_i  (in_retired_count_i),
    .out_report_count_o  (out_report_count_o),
    .out_top_bins_sum_o  (out_top_bins_sum_o),
    .out_nonzero_bins_o  (out_nonzero_bins_o),
    .out_all_bins_sum_o  (out_all_bins_sum_o)
  );

endmodule

/* verif/tb_access_distance_diversity_profiler_unit.sv */
// Self-checking testbench for access_distance_diversity_profiler_unit.
// Uses addp_pkg and the top level; drives random instruction words with idle
// gaps and stalls, predicts every interval report and checks it field by field.
module tb_access_distance_diversity_profiler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SIZE    = 256;
  localparam int unsigned HISTORY_DEPTH = 16;
  localparam int unsigned TOP_N         = 8;
  localparam int unsigned SETTLE        = 400;   // > access + report latency
  localparam int unsigned WATCHDOG      = 20000;
  localparam int unsigned LONG_HOLD     = 1500;

  typedef struct {
    logic                           mem;
    logic [addp_pkg::ADDR_W-1:0]    addr;
    logic [addp_pkg::COUNT_W-1:0]   count;
  } word_t;

  typedef struct {
    logic [addp_pkg::COUNT_W-1:0] count;
    logic [addp_pkg::SUM_W-1:0]   top;
    logic [addp_pkg::NZ_W-1:0]    nz;
    logic [addp_pkg::SUM_W-1:0]   all;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [addp_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_is_memory_i = 1'b0;
  logic [addp_pkg::ADDR_W-1:0] in_access_address_i = '0;
  logic [addp_pkg::COUNT_W-1:0] in_retired_count_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic [addp_pkg::COUNT_W-1:0] out_report_count_o;
  logic [addp_pkg::SUM_W-1:0] out_top_bins_sum_o, out_all_bins_sum_o;
  logic [addp_pkg::NZ_W-1:0] out_nonzero_bins_o;

  access_distance_diversity_profiler_unit #(
    .TABLE_SIZE(TABLE_SIZE), .HISTORY_DEPTH(HISTORY_DEPTH), .TOP_N(TOP_N)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_is_memory_i, .in_access_address_i,
    .in_retired_count_i, .out_valid_o, .out_stall_i, .out_report_count_o,
    .out_top_bins_sum_o, .out_nonzero_bins_o, .out_all_bins_sum_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [addp_pkg::BLOCK_W-1:0] hist_blocks [HISTORY_DEPTH];
  int unsigned                  hist_fill = 0;
  int unsigned                  hist_head = 0;
  logic [addp_pkg::BIN_W-1:0]   dist_bins [TABLE_SIZE];
  logic [addp_pkg::CFG_W-1:0]   ival_len = addp_pkg::INTERVAL_RESET;
  logic [addp_pkg::CFG_W-1:0]   ival_count = '0;
  logic [addp_pkg::CFG_W-1:0]   ival_drift = '0;

  word_t   pending_words[$];
  report_t report_q[$];
  int unsigned fails = 0, words_in = 0, reports_out = 0, mem_words = 0;
  bit calm = 1'b0;       // no idling on either side
  bit hold_done = 1'b0;

  initial for (int i = 0; i < TABLE_SIZE; i++) dist_bins[i] = '0;

  function automatic void profile_word(input word_t w);
    logic [addp_pkg::BLOCK_W-1:0] blk, d;
    logic [addp_pkg::CFG_W:0]     sum;
    logic [addp_pkg::CFG_W-1:0]   len;
    logic [addp_pkg::BIN_W-1:0]   sorted [TABLE_SIZE];
    logic [addp_pkg::BIN_W-1:0]   t;
    longint unsigned              top, all;
    int unsigned                  nz, best;
    report_t                      r;
    if (w.mem) begin
      blk = w.addr[addp_pkg::ADDR_W-1:addp_pkg::BLOCK_SHIFT];
      for (int i = 0; i < hist_fill; i++) begin
        d = blk - hist_blocks[i];
        if (dist_bins[d % TABLE_SIZE] != addp_pkg::BIN_MAX) dist_bins[d % TABLE_SIZE]++;
      end
      hist_blocks[hist_head] = blk;
      hist_head = (hist_head + 1) % HISTORY_DEPTH;
      if (hist_fill < HISTORY_DEPTH) hist_fill++;
    end
    ival_count++;
    sum = {1'b0, ival_count} + {1'b0, ival_drift};
    len = (ival_len == 0) ? 1 : ival_len;
    if (sum >= len) begin
      top = 0; all = 0; nz = 0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        sorted[i] = dist_bins[i];
        all += dist_bins[i];
        if (dist_bins[i] != 0) nz++;
      end
      for (int i = 0; i < TOP_N && i < TABLE_SIZE; i++) begin
        best = i;
        for (int j = i + 1; j < TABLE_SIZE; j++)
          if (sorted[j] > sorted[best]) best = j;
        t = sorted[i]; sorted[i] = sorted[best]; sorted[best] = t;
        top += sorted[i];
      end
      r.count = w.count;
      r.top = top[addp_pkg::SUM_W-1:0];
      r.nz = nz[addp_pkg::NZ_W-1:0];
      r.all = all[addp_pkg::SUM_W-1:0];
      report_q = {report_q, r};
      ival_drift = addp_pkg::CFG_W'(sum - len);
      ival_count = '0;
      for (int i = 0; i < TABLE_SIZE; i++) dist_bins[i] = '0;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    bit    taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        w.mem = in_is_memory_i;
        w.addr = in_access_address_i;
        w.count = in_retired_count_i;
        profile_word(w);
        words_in++;
        if (w.mem) mem_words++;
      end
      if (!in_valid_i || taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words[0];
          pending_words.delete(0);
          in_is_memory_i <= w.mem;
          in_access_address_i <= w.addr;
          in_retired_count_i <= w.count;
          in_valid_i <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  int unsigned out_hold = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    report_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        reports_out++;
        if (report_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected report count=%h", $time, out_report_count_o);
        end else begin
          e = report_q[0];
          report_q.delete(0);
          if (e.count !== out_report_count_o || e.top !== out_top_bins_sum_o ||
              e.nz !== out_nonzero_bins_o || e.all !== out_all_bins_sum_o) begin
            fails++;
            $display("%0t: report mismatch exp count=%h top=%h nz=%0d all=%h", $time,
                     e.count, e.top, e.nz, e.all);
            $display("%0t:                 got count=%h top=%h nz=%0d all=%h", $time,
                     out_report_count_o, out_top_bins_sum_o, out_nonzero_bins_o,
                     out_all_bins_sum_o);
          end
        end
        // one long hold-off so the block backs up into its input
        if (reports_out == 5 && !hold_done) begin
          hold_done = 1'b1;
          out_hold = LONG_HOLD;
        end
      end
      if (out_hold == 0 && !calm && $urandom_range(0, 1)) out_hold = pick_gap();
      out_stall_i <= (out_hold != 0);
      if (out_hold > 0) out_hold--;
    end
  end

  // watchdog on lack of progress
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d reports outstanding", $time, report_q.size());
      $display("tb_access_distance_diversity_profiler_unit: FAIL");
      $finish;
    end
  end

  logic [addp_pkg::COUNT_W-1:0] run_count = '0;
  logic [addp_pkg::ADDR_W-1:0]  base_addr = '0;

  task automatic add_word(input logic mem, input logic [addp_pkg::ADDR_W-1:0] a,
                          input logic [addp_pkg::COUNT_W-1:0] c);
    word_t w;
    w.mem = mem; w.addr = a; w.count = c;
    pending_words = {pending_words, w};
  endtask

  // mostly local accesses around a moving base so distances repeat
  task automatic add_random(input int unsigned n);
    int unsigned r;
    logic [addp_pkg::ADDR_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) base_addr = {$urandom, $urandom};
      if (r < 20) a = {$urandom, $urandom};
      else if (r < 30) a = base_addr;
      else a = base_addr + ($urandom_range(0, 40) << addp_pkg::BLOCK_SHIFT)
                         + $urandom_range(0, 63);
      run_count = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                                              : run_count + $urandom_range(1, 5);
      add_word($urandom_range(0, 3) != 0, a, run_count);
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || report_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_interval(input logic [addp_pkg::CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    ival_len = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset interval length: nothing reports yet
    add_random(5);
    drain();

    // zero length counts as one: every word reports
    set_interval('0);
    add_word(1'b1, '0, '0);
    add_word(1'b1, '0, '1);                       // same block, distance zero
    add_word(1'b1, '1, 64'h8000_0000_0000_0000);
    add_word(1'b1, 64'h3F, 64'd1);                // same block as address zero
    add_word(1'b0, '1, 64'd2);                    // not an access
    add_word(1'b1, 64'h40, 64'd3);
    add_word(1'b1, 64'hFFFF_FFFF_FFFF_FFC0, 64'd4);  // wraps around block zero
    add_word(1'b1, 64'h4000, 64'd5);              // distance 256 lands in bin 0
    for (int i = 0; i < 12; i++)
      add_word(1'b1, 64'h1000 + (i << addp_pkg::BLOCK_SHIFT), 64'd6 + i);  // fill the history
    drain();

    set_interval(32'd1);
    add_random(150);
    drain();

    set_interval('1);                             // never closes in this run
    add_random(50);
    drain();

    set_interval(32'd3);
    calm = 1'b1;
    add_random(60);
    drain();
    calm = 1'b0;

    set_interval(32'd20);
    add_random(200);
    drain();

    set_interval(32'd7);
    add_random(120);
    drain();

    $display("covered %0d words (%0d accesses), %0d interval reports checked",
             words_in, mem_words, reports_out);
    $display("interval lengths 0, 1, 3, 7, 20, max and reset value; long output hold");
    if (fails == 0) begin
      $display("tb_access_distance_diversity_profiler_unit: PASS");
    end else begin
      $display("tb_access_distance_diversity_profiler_unit: FAIL");
    end
    $finish;
  end

endmodule
